// File: hdl/hpg_pkg.sv
`timescale 1ns / 1ps

package hpg_pkg;

   localparam int WALL_W  = 64;
   localparam int TIME_W  = 32;
   localparam int FREQ_W  = 32;
   localparam int LOAD_W  = 7;
   localparam int CNT_W   = 6;
   localparam int SECS_W  = 7;
   localparam int ACT_W   = 2;

   // dividend of both divisions: 100 * 32-bit busy time, or 7-bit load * 32-bit freq
   localparam int NUM_W     = 39;
   localparam int DEN_W     = 32;
   localparam int QUOT_W    = 7;
   localparam int DIV_STEPS = NUM_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   localparam int APB_AW = 5;
   localparam int APB_DW = 32;

   localparam logic [NUM_W-1:0]  PCT_SCALE  = NUM_W'(100);
   localparam logic [LOAD_W-1:0] LOAD_MAX   = LOAD_W'(100);
   localparam logic [CNT_W-1:0]  CNT_SAT    = CNT_W'(63);
   localparam logic [CNT_W:0]    CNT_STEP   = (CNT_W+1)'(2);
   localparam logic [CNT_W:0]    REFILL_ADD = (CNT_W+1)'(5);

   localparam logic [6:0]  RST_LOAD_THR  = 7'd60;
   localparam logic [5:0]  RST_HIGH_CNT  = 6'd10;
   localparam logic [5:0]  RST_MAX_CNT   = 6'd20;
   localparam logic [31:0] RST_FREQ_LIM  = 32'd1000000;
   localparam logic [6:0]  RST_MIN_SECS  = 7'd1;

   typedef enum logic [2:0] {
      REG_LOAD_THR = 3'd0,
      REG_HIGH_CNT = 3'd1,
      REG_MAX_CNT  = 3'd2,
      REG_FREQ_LIM = 3'd3,
      REG_MIN_SECS = 3'd4
   } hpg_reg_type;

   typedef enum logic [ACT_W-1:0] {
      ACT_NONE    = 2'd0,
      ACT_ONLINE  = 2'd1,
      ACT_OFFLINE = 2'd2
   } hpg_action_type;

   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  num;
      logic [DEN_W-1:0]  den;
   } hpg_div_req_type;

   typedef struct packed {
      logic              done;
      logic              big;
      logic [QUOT_W-1:0] quot;
   } hpg_div_rsp_type;

endpackage

// File: hdl/hpg_div.sv
`timescale 1ns / 1ps

// Bit-serial restoring divider: one dividend bit per cycle, MSB first.
// Only the low quotient bits are kept; big flags any higher set bit.
module hpg_div (
   input  logic                     clock,
   input  logic                     reset,
   input  hpg_pkg::hpg_div_req_type req,
   output hpg_pkg::hpg_div_rsp_type rsp
);

   logic [hpg_pkg::NUM_W-1:0]  nsh_ff, nsh_in;
   logic [hpg_pkg::DEN_W-1:0]  den_ff, den_in;
   logic [hpg_pkg::DEN_W-1:0]  rem_ff, rem_in;
   logic [hpg_pkg::QUOT_W-1:0] quot_ff, quot_in;
   logic                       big_ff, big_in;
   logic [hpg_pkg::STEP_W-1:0] step_ff, step_in;
   logic                       run_ff, run_in;
   logic                       done_ff, done_in;

   logic [hpg_pkg::DEN_W:0] trial;
   logic [hpg_pkg::DEN_W:0] diff;
   logic                    fits;

   always_comb begin
      trial = {rem_ff, nsh_ff[hpg_pkg::NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});

      nsh_in  = nsh_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;
      big_in  = big_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;

      if (req.start) begin
         nsh_in  = req.num;
         den_in  = req.den;
         rem_in  = '0;
         quot_in = '0;
         big_in  = 1'b0;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         nsh_in  = {nsh_ff[hpg_pkg::NUM_W-2:0], 1'b0};
         rem_in  = fits ? diff[hpg_pkg::DEN_W-1:0] : trial[hpg_pkg::DEN_W-1:0];
         quot_in = {quot_ff[hpg_pkg::QUOT_W-2:0], fits};
         big_in  = big_ff | quot_ff[hpg_pkg::QUOT_W-1];
         step_in = step_ff + 1'b1;
         if (step_ff == hpg_pkg::STEP_W'(hpg_pkg::DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      nsh_ff  <= nsh_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      big_ff  <= big_in;
   end

   assign rsp.done = done_ff;
   assign rsp.big  = big_ff;
   assign rsp.quot = quot_ff;

`ifndef SYNTHESIS
   a_start_runs : assert property (@(posedge clock) disable iff (reset)
      req.start |=> run_ff && !done_ff)
      else $error("divider did not start");
   a_done_once : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff && $past(run_ff))
      else $error("divider done without a run");
   a_rem_below : assert property (@(posedge clock) disable iff (reset)
      run_ff && !req.start |-> rem_ff < den_ff || den_ff == '0)
      else $error("divider remainder out of range");
`endif

endmodule

// File: hdl/core_hotplug_load_governor_unit.sv
`timescale 1ns / 1ps

// Channel  | valid      | stall      | payload
// ---------+------------+------------+--------------------------------------------
// request  | req_valid  | req_stall  | req_mode .. req_now_ticks (one sample word)
// response | rsp_valid  | rsp_stall  | rsp_load_percent, rsp_action, rsp_counter_level
// config   | psel/penable/pwrite, pready always high, byte address 4*index
//
// One sample word at a time. A suspend word goes from idle straight to ST_OUT, which raises
// rsp_valid; a load sample passes ST_PREP, ST_MUL1, ST_DIV1, ST_MUL2, ST_DIV2 and ST_DECIDE first.
// Each divide takes 39 divider steps; the input is freed once ST_OUT passes on the result.
// Zero wall time or idle above wall skips both divides; zero load or freq_top skips the second.
// Reset is synchronous; it restores the register defaults and clears all pair history.
// The result waits in the output register under rsp_stall; a new word is taken meanwhile.
module core_hotplug_load_governor_unit #(
   parameter int TICKS_PER_SECOND = 100
) (
   input  logic                           clock,
   input  logic                           reset,

   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_mode,
   input  logic                           req_pair,
   input  logic [hpg_pkg::WALL_W-1:0]     req_wall_total,
   input  logic [hpg_pkg::WALL_W-1:0]     req_idle_total,
   input  logic [hpg_pkg::FREQ_W-1:0]     req_freq_now,
   input  logic [hpg_pkg::FREQ_W-1:0]     req_freq_top,
   input  logic                           req_partner_online,
   input  logic [hpg_pkg::FREQ_W-1:0]     req_partner_freq_min,
   input  logic [hpg_pkg::FREQ_W-1:0]     req_partner_freq_now,
   input  logic [hpg_pkg::TIME_W-1:0]     req_now_ticks,

   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hpg_pkg::LOAD_W-1:0]     rsp_load_percent,
   output logic [hpg_pkg::ACT_W-1:0]      rsp_action,
   output logic [hpg_pkg::CNT_W-1:0]      rsp_counter_level,

   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [hpg_pkg::APB_AW-1:0]     paddr,
   input  logic [hpg_pkg::APB_DW-1:0]     pwdata,
   output logic [hpg_pkg::APB_DW-1:0]     prdata,
   output logic                           pready
);

   localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
   localparam int HOLD_W = hpg_pkg::SECS_W + TPS_W;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_PREP   = 8'b0000_0010,
      ST_MUL1   = 8'b0000_0100,
      ST_DIV1   = 8'b0000_1000,
      ST_MUL2   = 8'b0001_0000,
      ST_DIV2   = 8'b0010_0000,
      ST_DECIDE = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [6:0]  load_thr_ff, load_thr_in;
   logic [5:0]  high_cnt_ff, high_cnt_in;
   logic [5:0]  max_cnt_ff, max_cnt_in;
   logic [31:0] freq_lim_ff, freq_lim_in;
   logic [6:0]  min_secs_ff, min_secs_in;
   logic        csr_wr;
   hpg_pkg::hpg_reg_type csr_idx;

   // per-pair history; only the low time bits feed the differences
   logic [hpg_pkg::TIME_W-1:0] last_wall_ff [2];
   logic [hpg_pkg::TIME_W-1:0] last_idle_ff [2];
   logic [hpg_pkg::CNT_W-1:0]  cnt_ff [2];
   logic [hpg_pkg::TIME_W-1:0] since_ff [2];

   // sample being worked
   logic                       pair_ff;
   logic [hpg_pkg::FREQ_W-1:0] fnow_ff, ftop_ff, pmin_ff, pcur_ff;
   logic                       pon_ff;
   logic [hpg_pkg::TIME_W-1:0] now_ff;
   logic [hpg_pkg::TIME_W-1:0] dw_ff, di_ff;
   logic [hpg_pkg::TIME_W-1:0] busy_ff;
   logic                       zero_ff;
   logic [hpg_pkg::TIME_W-1:0] deadline_ff;
   logic [hpg_pkg::FREQ_W-1:0] hold_ff;
   logic [hpg_pkg::NUM_W-1:0]  num_ff, num_in;
   logic                       start_ff, start_in;
   logic [hpg_pkg::LOAD_W-1:0] load_ff, load_in;

   logic [hpg_pkg::LOAD_W-1:0] res_load_ff, res_load_in;
   logic [hpg_pkg::ACT_W-1:0]  res_act_ff, res_act_in;
   logic [hpg_pkg::CNT_W-1:0]  res_cnt_ff, res_cnt_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [hpg_pkg::LOAD_W-1:0] rsp_load_ff;
   logic [hpg_pkg::ACT_W-1:0]  rsp_act_ff;
   logic [hpg_pkg::CNT_W-1:0]  rsp_cnt_ff;

   hpg_pkg::hpg_div_req_type div_req;
   hpg_pkg::hpg_div_rsp_type div_rsp;

   logic                       accept;
   logic                       out_free;
   logic [hpg_pkg::TIME_W:0]   busy_diff;
   logic [HOLD_W-1:0]          hold_ticks;
   logic [hpg_pkg::TIME_W-1:0] early_diff;
   logic                       high_load;
   logic [hpg_pkg::CNT_W-1:0]  cnt_cur, cnt_new;
   logic [hpg_pkg::CNT_W:0]    cnt_inc, refill;
   hpg_pkg::hpg_action_type    act_new;
   logic                       go_online;
   logic                       clamp_hit;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // config port
   assign pready  = 1'b1;
   assign csr_idx = hpg_pkg::hpg_reg_type'(paddr[4:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      load_thr_in = load_thr_ff;
      high_cnt_in = high_cnt_ff;
      max_cnt_in  = max_cnt_ff;
      freq_lim_in = freq_lim_ff;
      min_secs_in = min_secs_ff;
      prdata      = '0;
      case (csr_idx)
         hpg_pkg::REG_LOAD_THR: begin
            prdata = 32'(load_thr_ff);
            if (csr_wr) load_thr_in = pwdata[6:0];
         end
         hpg_pkg::REG_HIGH_CNT: begin
            prdata = 32'(high_cnt_ff);
            if (csr_wr) high_cnt_in = pwdata[5:0];
         end
         hpg_pkg::REG_MAX_CNT: begin
            prdata = 32'(max_cnt_ff);
            if (csr_wr) max_cnt_in = pwdata[5:0];
         end
         hpg_pkg::REG_FREQ_LIM: begin
            prdata = freq_lim_ff;
            if (csr_wr) freq_lim_in = pwdata;
         end
         hpg_pkg::REG_MIN_SECS: begin
            prdata = 32'(min_secs_ff);
            if (csr_wr) min_secs_in = pwdata[6:0];
         end
         default: prdata = '0;
      endcase
   end

   // datapath helpers
   assign busy_diff  = {1'b0, dw_ff} - {1'b0, di_ff};
   assign hold_ticks = HOLD_W'(min_secs_ff) * HOLD_W'(TICKS_PER_SECOND);
   assign early_diff = now_ff - deadline_ff;
   assign clamp_hit  = div_rsp.big || (div_rsp.quot > hpg_pkg::LOAD_MAX);

   // hysteresis decision
   always_comb begin
      cnt_cur    = cnt_ff[pair_ff];
      high_load  = (load_ff >= load_thr_ff);
      cnt_inc    = {1'b0, cnt_cur} + hpg_pkg::CNT_STEP;
      refill     = {1'b0, high_cnt_ff} + hpg_pkg::REFILL_ADD;
      cnt_new    = cnt_cur;
      act_new    = hpg_pkg::ACT_NONE;
      go_online  = 1'b0;
      if (high_load) begin
         if (cnt_cur < max_cnt_ff)
            cnt_new = cnt_inc[hpg_pkg::CNT_W] ? hpg_pkg::CNT_SAT : cnt_inc[hpg_pkg::CNT_W-1:0];
         if (!pon_ff && (cnt_new >= high_cnt_ff)) begin
            act_new   = hpg_pkg::ACT_ONLINE;
            go_online = 1'b1;
         end
      end else begin
         if (cnt_cur != '0)
            cnt_new = cnt_cur - 1'b1;
         if (pon_ff && (cnt_new < high_cnt_ff)) begin
            if (pcur_ff > hold_ff) begin
               // partner still runs fast: refill
               cnt_new = refill[hpg_pkg::CNT_W] ? hpg_pkg::CNT_SAT : refill[hpg_pkg::CNT_W-1:0];
            end else if (!early_diff[hpg_pkg::TIME_W-1]) begin
               act_new    = hpg_pkg::ACT_OFFLINE;
               cnt_new    = '0;
            end
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      num_in       = num_ff;
      start_in     = 1'b0;
      load_in      = load_ff;
      res_load_in  = res_load_ff;
      res_act_in   = res_act_ff;
      res_cnt_in   = res_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode) begin
                  res_load_in = '0;
                  res_act_in  = hpg_pkg::ACT_NONE;
                  res_cnt_in  = '0;
                  state_in    = ST_OUT;
               end else begin
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: state_in = ST_MUL1;
         ST_MUL1: begin
            if (zero_ff) begin
               load_in  = '0;
               state_in = ST_DECIDE;
            end else begin
               num_in   = hpg_pkg::NUM_W'(busy_ff) * hpg_pkg::PCT_SCALE;
               start_in = 1'b1;
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_rsp.done) begin
               load_in  = div_rsp.quot;
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if ((ftop_ff == '0) || (load_ff == '0)) begin
               load_in  = '0;
               state_in = ST_DECIDE;
            end else begin
               num_in   = hpg_pkg::NUM_W'(load_ff) * hpg_pkg::NUM_W'(fnow_ff);
               start_in = 1'b1;
               state_in = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_rsp.done) begin
               load_in  = clamp_hit ? hpg_pkg::LOAD_MAX : div_rsp.quot;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            res_load_in = load_ff;
            res_act_in  = act_new;
            res_cnt_in  = cnt_new;
            state_in    = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign div_req.start = start_ff;
   assign div_req.num   = num_ff;
   assign div_req.den   = (state_ff == ST_DIV2) ? ftop_ff : dw_ff;

   hpg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         start_ff        <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         load_thr_ff     <= hpg_pkg::RST_LOAD_THR;
         high_cnt_ff     <= hpg_pkg::RST_HIGH_CNT;
         max_cnt_ff      <= hpg_pkg::RST_MAX_CNT;
         freq_lim_ff     <= hpg_pkg::RST_FREQ_LIM;
         min_secs_ff     <= hpg_pkg::RST_MIN_SECS;
         last_wall_ff[0] <= '0;
         last_wall_ff[1] <= '0;
         last_idle_ff[0] <= '0;
         last_idle_ff[1] <= '0;
         cnt_ff[0]       <= '0;
         cnt_ff[1]       <= '0;
         since_ff[0]     <= '0;
         since_ff[1]     <= '0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         load_thr_ff  <= load_thr_in;
         high_cnt_ff  <= high_cnt_in;
         max_cnt_ff   <= max_cnt_in;
         freq_lim_ff  <= freq_lim_in;
         min_secs_ff  <= min_secs_in;
         if (accept) begin
            if (req_mode) begin
               cnt_ff[0] <= '0;
               cnt_ff[1] <= '0;
            end else begin
               last_wall_ff[req_pair] <= req_wall_total[hpg_pkg::TIME_W-1:0];
               last_idle_ff[req_pair] <= req_idle_total[hpg_pkg::TIME_W-1:0];
            end
         end
         if (state_ff == ST_DECIDE) begin
            cnt_ff[pair_ff] <= cnt_new;
            if (go_online)
               since_ff[pair_ff] <= now_ff;
         end
      end

      if (accept) begin
         pair_ff <= req_pair;
         fnow_ff <= req_freq_now;
         ftop_ff <= req_freq_top;
         pon_ff  <= req_partner_online;
         pmin_ff <= req_partner_freq_min;
         pcur_ff <= req_partner_freq_now;
         now_ff  <= req_now_ticks;
         dw_ff   <= req_wall_total[hpg_pkg::TIME_W-1:0] - last_wall_ff[req_pair];
         di_ff   <= req_idle_total[hpg_pkg::TIME_W-1:0] - last_idle_ff[req_pair];
      end
      if (state_ff == ST_PREP) begin
         busy_ff     <= busy_diff[hpg_pkg::TIME_W-1:0];
         zero_ff     <= (dw_ff == '0) || busy_diff[hpg_pkg::TIME_W];
         deadline_ff <= since_ff[pair_ff] + hpg_pkg::TIME_W'(hold_ticks);
         hold_ff     <= (pmin_ff > freq_lim_ff) ? freq_lim_ff : pmin_ff;
      end
      num_ff      <= num_in;
      load_ff     <= load_in;
      res_load_ff <= res_load_in;
      res_act_ff  <= res_act_in;
      res_cnt_ff  <= res_cnt_in;
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_load_ff <= res_load_ff;
         rsp_act_ff  <= res_act_ff;
         rsp_cnt_ff  <= res_cnt_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_load_percent  = rsp_load_ff;
   assign rsp_action        = rsp_act_ff;
   assign rsp_counter_level = rsp_cnt_ff;

`ifndef SYNTHESIS
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("took a second word while busy");
   a_load_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_load_percent <= hpg_pkg::LOAD_MAX)
      else $error("load above 100");
   a_offline_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == hpg_pkg::ACT_OFFLINE |-> rsp_counter_level == '0)
      else $error("offline request left counter nonzero");
   a_action_code : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_action == hpg_pkg::ACT_NONE || rsp_action == hpg_pkg::ACT_ONLINE
                    || rsp_action == hpg_pkg::ACT_OFFLINE)
      else $error("bad action code");
`endif

endmodule

// File: verif/core_hotplug_load_governor_unit_tb.sv
`timescale 1ns / 1ps

module core_hotplug_load_governor_unit_tb;

   localparam int TPS          = 100;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int BLOCK_ITEMS  = 275;
   localparam logic [31:0] F_NOM = 32'd1000000;

   typedef struct {
      logic        mode;
      logic        pair;
      logic [63:0] wall;
      logic [63:0] idle;
      logic [31:0] fnow;
      logic [31:0] ftop;
      logic        pon;
      logic [31:0] pmin;
      logic [31:0] pnow;
      logic [31:0] now;
   } hpg_sample_type;

   typedef struct {
      logic [hpg_pkg::LOAD_W-1:0] load;
      hpg_pkg::hpg_action_type    action;
      logic [hpg_pkg::CNT_W-1:0]  level;
   } gov_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_stall;
   logic              req_mode = 1'b0;
   logic              req_pair = 1'b0;
   logic [63:0]       req_wall_total = '0;
   logic [63:0]       req_idle_total = '0;
   logic [31:0]       req_freq_now = '0;
   logic [31:0]       req_freq_top = '0;
   logic              req_partner_online = 1'b0;
   logic [31:0]       req_partner_freq_min = '0;
   logic [31:0]       req_partner_freq_now = '0;
   logic [31:0]       req_now_ticks = '0;

   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [hpg_pkg::LOAD_W-1:0] rsp_load_percent;
   logic [hpg_pkg::ACT_W-1:0]  rsp_action;
   logic [hpg_pkg::CNT_W-1:0]  rsp_counter_level;

   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [hpg_pkg::APB_AW-1:0] paddr = '0;
   logic [hpg_pkg::APB_DW-1:0] pwdata = '0;
   logic [hpg_pkg::APB_DW-1:0] prdata;
   logic                       pready;

   // register shadow
   logic [6:0]  cfg_thr  = hpg_pkg::RST_LOAD_THR;
   logic [5:0]  cfg_high = hpg_pkg::RST_HIGH_CNT;
   logic [5:0]  cfg_max  = hpg_pkg::RST_MAX_CNT;
   logic [31:0] cfg_flim = hpg_pkg::RST_FREQ_LIM;
   logic [6:0]  cfg_secs = hpg_pkg::RST_MIN_SECS;

   // governor state shadow
   logic [63:0]               hist_wall [2] = '{default: '0};
   logic [63:0]               hist_idle [2] = '{default: '0};
   logic [hpg_pkg::CNT_W-1:0] lvl [2]       = '{default: '0};
   logic [31:0]               since [2]     = '{default: '0};

   // stimulus generator state
   logic [63:0] gen_wall [2]    = '{default: '0};
   logic [63:0] gen_idle [2]    = '{default: '0};
   logic        gen_partner [2] = '{default: 1'b0};
   logic [31:0] gen_now         = 32'd1000;

   hpg_sample_type  sample_q [$];
   gov_verdict_type verdict_q [$];
   hpg_sample_type  cur;
   gov_verdict_type want;

   int snd_idle_pct  = 16;
   int rcv_stall_pct = 88;
   int mismatch_count = 0;
   int cycle_count = 0;

   core_hotplug_load_governor_unit #(
      .TICKS_PER_SECOND(TPS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_pair(req_pair),
      .req_wall_total(req_wall_total),
      .req_idle_total(req_idle_total),
      .req_freq_now(req_freq_now),
      .req_freq_top(req_freq_top),
      .req_partner_online(req_partner_online),
      .req_partner_freq_min(req_partner_freq_min),
      .req_partner_freq_now(req_partner_freq_now),
      .req_now_ticks(req_now_ticks),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_load_percent(rsp_load_percent),
      .rsp_action(rsp_action),
      .rsp_counter_level(rsp_counter_level),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #2 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] exp_val);
      mismatch_count++;
      if (mismatch_count <= 50) begin
         $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, exp_val,
                  cycle_count);
      end
   endtask

   function automatic gov_verdict_type predict_governor(input hpg_sample_type s);
      gov_verdict_type v;
      logic [31:0]  dw;
      logic [31:0]  di;
      logic [31:0]  hold;
      logic [31:0]  deadline;
      logic [31:0]  gap;
      logic [63:0]  raw;
      logic [63:0]  scaled;
      logic [6:0]   load;
      logic [6:0]   sum;
      logic         p;
      v.load = '0;
      v.action = hpg_pkg::ACT_NONE;
      v.level = '0;
      if (s.mode) begin
         lvl[0] = '0;
         lvl[1] = '0;
         return v;
      end
      p = s.pair;
      // deltas keep only their low 32 bits
      dw = 32'(s.wall - hist_wall[p]);
      di = 32'(s.idle - hist_idle[p]);
      hist_wall[p] = s.wall;
      hist_idle[p] = s.idle;
      if (dw == 0 || dw < di || s.ftop == 0) begin
         load = '0;
      end else begin
         raw = (64'd100 * 64'(dw - di)) / 64'(dw);
         scaled = (raw * 64'(s.fnow)) / 64'(s.ftop);
         load = (scaled > 64'd100) ? 7'd100 : 7'(scaled);
      end
      if (load >= cfg_thr) begin
         if (lvl[p] < cfg_max) begin
            sum = 7'(lvl[p]) + 7'd2;
            lvl[p] = (sum > 7'd63) ? 6'd63 : 6'(sum);
         end
         if (!s.pon && lvl[p] >= cfg_high) begin
            v.action = hpg_pkg::ACT_ONLINE;
            since[p] = s.now;
         end
      end else begin
         if (lvl[p] != 0) lvl[p] = lvl[p] - 6'd1;
         if (s.pon && lvl[p] < cfg_high) begin
            hold = (s.pmin > cfg_flim) ? cfg_flim : s.pmin;
            if (s.pnow > hold) begin
               // partner still fast: refill
               sum = 7'(cfg_high) + 7'd5;
               lvl[p] = (sum > 7'd63) ? 6'd63 : 6'(sum);
            end else begin
               deadline = since[p] + 32'(cfg_secs) * 32'(TPS);
               gap = s.now - deadline;
               if (!gap[31]) begin
                  v.action = hpg_pkg::ACT_OFFLINE;
                  lvl[p] = '0;
               end
            end
         end
      end
      v.load = load;
      v.level = lvl[p];
      return v;
   endfunction

   // sample built from deltas on the generator's running totals
   function automatic hpg_sample_type step_sample(input logic m, input logic p,
                                               input logic [63:0] dw, input logic [63:0] di,
                                               input logic [31:0] fnow, input logic [31:0] ftop,
                                               input logic pon, input logic [31:0] pmin,
                                               input logic [31:0] pnow, input logic [31:0] dt);
      hpg_sample_type s;
      gen_now = gen_now + dt;
      s.mode = m;
      s.pair = p;
      s.wall = gen_wall[p] + dw;
      s.idle = gen_idle[p] + di;
      s.fnow = fnow;
      s.ftop = ftop;
      s.pon = pon;
      s.pmin = pmin;
      s.pnow = pnow;
      s.now = gen_now;
      if (!m) begin
         gen_wall[p] = s.wall;
         gen_idle[p] = s.idle;
      end
      return s;
   endfunction

   function automatic hpg_sample_type noise_sample();
      hpg_sample_type s;
      s.mode = ($urandom_range(0, 7) == 0);
      s.pair = 1'($urandom_range(0, 1));
      s.wall = {$urandom, $urandom};
      s.idle = ($urandom_range(0, 1) != 0) ? {$urandom, $urandom} : s.wall - $urandom;
      s.fnow = $urandom;
      s.ftop = ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom;
      s.pon = 1'($urandom_range(0, 1));
      s.pmin = $urandom;
      s.pnow = $urandom;
      s.now = $urandom;
      if (!s.mode) begin
         gen_wall[s.pair] = s.wall;
         gen_idle[s.pair] = s.idle;
      end
      return s;
   endfunction

   function automatic hpg_sample_type rand_sample();
      logic        p;
      logic [31:0] dw;
      logic [31:0] di;
      logic [31:0] ftop;
      logic [31:0] fnow;
      logic [31:0] pmin;
      logic [31:0] pnow;
      logic [31:0] hold;
      logic [31:0] dt;
      int          pct;
      int          pick;
      p = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
         return step_sample(1'b1, p, 64'd0, 64'd0, $urandom, $urandom,
                            1'($urandom_range(0, 1)), $urandom, $urandom,
                            $urandom_range(0, 50));
      end
      if (pick < 17) return noise_sample();
      dw = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(1, 5000);
      pct = $urandom_range(0, 100);
      di = dw - 32'((64'(dw) * 64'(pct)) / 64'd100);
      ftop = $urandom_range(300000, 3000000);
      case ($urandom_range(0, 3))
         0, 1: fnow = ftop;
         2: fnow = $urandom_range(0, ftop);
         default: fnow = ftop + $urandom_range(0, ftop);
      endcase
      if ($urandom_range(0, 5) == 0) gen_partner[p] = ~gen_partner[p];
      pmin = $urandom_range(100000, 2000000);
      hold = (pmin > cfg_flim) ? cfg_flim : pmin;
      if ($urandom_range(0, 4) < 3) pnow = $urandom_range(0, hold);
      else pnow = hold + $urandom_range(1, 500000);
      dt = ($urandom_range(0, 63) == 0) ? $urandom : $urandom_range(0, 400);
      return step_sample(1'b0, p, 64'(dw), 64'(di), fnow, ftop, gen_partner[p], pmin, pnow, dt);
   endfunction

   task automatic write_reg(input hpg_pkg::hpg_reg_type idx, input logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      penable <= 1'b0;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         hpg_pkg::REG_LOAD_THR: cfg_thr = val[6:0];
         hpg_pkg::REG_HIGH_CNT: cfg_high = val[5:0];
         hpg_pkg::REG_MAX_CNT:  cfg_max = val[5:0];
         hpg_pkg::REG_FREQ_LIM: cfg_flim = val;
         hpg_pkg::REG_MIN_SECS: cfg_secs = val[6:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [31:0] thr, input logic [31:0] high,
                                input logic [31:0] maxc, input logic [31:0] flim,
                                input logic [31:0] secs);
      write_reg(hpg_pkg::REG_LOAD_THR, thr);
      write_reg(hpg_pkg::REG_HIGH_CNT, high);
      write_reg(hpg_pkg::REG_MAX_CNT, maxc);
      write_reg(hpg_pkg::REG_FREQ_LIM, flim);
      write_reg(hpg_pkg::REG_MIN_SECS, secs);
   endtask

   // sampled on the falling edge, clear of the driver and monitor
   task automatic wait_idle();
      while (sample_q.size() != 0 || req_valid || verdict_q.size() != 0) @(negedge clock);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) verdict_q.push_back(predict_governor(cur));
         if (!req_valid || !req_stall) begin
            if (sample_q.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
               cur = sample_q.pop_front();
               req_mode <= cur.mode;
               req_pair <= cur.pair;
               req_wall_total <= cur.wall;
               req_idle_total <= cur.idle;
               req_freq_now <= cur.fnow;
               req_freq_top <= cur.ftop;
               req_partner_online <= cur.pon;
               req_partner_freq_min <= cur.pmin;
               req_partner_freq_now <= cur.pnow;
               req_now_ticks <= cur.now;
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < rcv_stall_pct);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            report_mismatch("word with nothing pending", 64'(rsp_load_percent), 64'd0);
         end else begin
            want = verdict_q.pop_front();
            if (rsp_load_percent !== want.load)
               report_mismatch("load_percent", 64'(rsp_load_percent), 64'(want.load));
            if (rsp_action !== want.action)
               report_mismatch("action", 64'(rsp_action), 64'(want.action));
            if (rsp_counter_level !== want.level)
               report_mismatch("counter_level", 64'(rsp_counter_level), 64'(want.level));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      hpg_sample_type s;
      int             i;
      int             b;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: corner loads on pair 0
      sample_q.push_back(step_sample(1'b0, 1'b0, 0, 0, F_NOM, F_NOM, 1'b0, F_NOM, F_NOM, 1));
      sample_q.push_back(step_sample(1'b0, 1'b0, 1000, 0, F_NOM, F_NOM, 1'b0, F_NOM, F_NOM, 1));
      sample_q.push_back(step_sample(1'b0, 1'b0, 100, 200, F_NOM, F_NOM, 1'b0, F_NOM, F_NOM, 1));
      sample_q.push_back(step_sample(1'b0, 1'b0, 1000, 0, F_NOM, 0, 1'b0, F_NOM, F_NOM, 1));
      sample_q.push_back(step_sample(1'b0, 1'b0, 1000, 500, 4 * F_NOM, F_NOM, 1'b0, F_NOM,
                                     F_NOM, 1));
      s.mode = 1'b0;
      s.pair = 1'b0;
      s.wall = '1;
      s.idle = '1;
      s.fnow = '1;
      s.ftop = '1;
      s.pon = 1'b1;
      s.pmin = '1;
      s.pnow = '1;
      s.now = '1;
      gen_wall[0] = s.wall;
      gen_idle[0] = s.idle;
      sample_q.push_back(s);
      // full 32-bit busy time
      sample_q.push_back(step_sample(1'b0, 1'b0, 64'hFFFF_FFFF, 0, F_NOM, F_NOM, 1'b0, F_NOM,
                                     F_NOM, 1));

      // pair 1: climb to online, refill, early hold, then removal
      for (i = 0; i < 6; i++)
         sample_q.push_back(step_sample(1'b0, 1'b1, 1000, 0, F_NOM, F_NOM, i == 5, F_NOM,
                                        F_NOM, 1));
      for (i = 0; i < 9; i++)
         sample_q.push_back(step_sample(1'b0, 1'b1, 1000, 1000, F_NOM, F_NOM, 1'b1, F_NOM,
                                        (i == 2) ? 2 * F_NOM : F_NOM, 1));
      sample_q.push_back(step_sample(1'b0, 1'b1, 1000, 1000, F_NOM, F_NOM, 1'b1, F_NOM, F_NOM,
                                     200));
      sample_q.push_back(step_sample(1'b1, 1'b1, 0, 0, '1, '1, 1'b1, '1, '1, 1));

      for (b = 0; b < 6; b++) begin
         wait_idle();
         if (b < 2) begin
            snd_idle_pct = 16;
            rcv_stall_pct = 88;
         end else if (b < 4) begin
            snd_idle_pct = 88;
            rcv_stall_pct = 16;
         end else begin
            snd_idle_pct = 0;
            rcv_stall_pct = 0;
         end
         case (b)
            0: apply_setting(40, 6, 12, 800000, 0);
            1: apply_setting(0, 0, 0, 0, 0);
            2: apply_setting(100, 50, 50, 32'hFFFF_FFFF, 100);
            3: apply_setting(30, 63, 63, 1500000, 2);
            4: apply_setting(127, 5, 8, 500000, 127);
            default: apply_setting(32'(hpg_pkg::RST_LOAD_THR), 32'(hpg_pkg::RST_HIGH_CNT),
                                   32'(hpg_pkg::RST_MAX_CNT), hpg_pkg::RST_FREQ_LIM,
                                   32'(hpg_pkg::RST_MIN_SECS));
         endcase
         for (i = 0; i < BLOCK_ITEMS / 2; i++) sample_q.push_back(rand_sample());
         // sender holds off until the first half of the block has drained
         wait_idle();
         for (i = BLOCK_ITEMS / 2; i < BLOCK_ITEMS; i++) sample_q.push_back(rand_sample());
      end

      wait_idle();
      repeat (100) @(posedge clock);
      if (verdict_q.size() != 0)
         report_mismatch("words still pending", 64'(verdict_q.size()), 64'd0);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
